FILE: rtl/cc2v_pkg.sv
// cc2v_pkg: shared types and constants for the 2d valid-mode cross-correlation unit
// beat structs, register indexes, operation codes and datapath widths
// no dependencies
package cc2v_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_KERNEL = 5;
    localparam int PIXEL_BITS = 16;

    localparam int KSLOTS   = MAX_KERNEL * MAX_KERNEL;
    localparam int SLOT_W   = $clog2(MAX_KERNEL);
    localparam int ADDR_W   = $clog2(MAX_WIDTH);
    localparam int PROD_W   = 2 * PIXEL_BITS;
    localparam int ROW_W    = PROD_W + $clog2(MAX_KERNEL + 1);
    localparam int SUM_W    = 40;

    localparam int WIDTH_W  = 9;
    localparam int HEIGHT_W = 13;
    localparam int KDIM_W   = 3;
    localparam int ROWCNT_W = 12;
    localparam int CFG_W    = 13;
    localparam int CFGIDX_W = 2;
    localparam int KIDX_W   = 5;

    localparam logic [WIDTH_W-1:0]  WIDTH_MAX  = WIDTH_W'(MAX_WIDTH);
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = HEIGHT_W'(4096);
    localparam logic [KDIM_W-1:0]   KDIM_MAX   = KDIM_W'(MAX_KERNEL);

    localparam logic [CFGIDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFGIDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFGIDX_W-1:0] REG_KERNEL_ROWS  = 2'd2;
    localparam logic [CFGIDX_W-1:0] REG_KERNEL_COLS  = 2'd3;

    localparam logic OP_COEF  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    typedef struct packed {
        logic                         op;
        logic [KIDX_W-1:0]            kernel_index;
        logic signed [PIXEL_BITS-1:0] value;
    } in_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic                    last;
    } out_t;

    typedef struct packed {
        logic shift;
        logic capture;
    } cell_ctrl_t;

endpackage

FILE: rtl/cc2v_line_buf.sv
// cc2v_line_buf: one bank of pixel storage per kernel row, written round-robin by row
// every bank is read at the current column in the same beat, read data registered
// depends on cc2v_pkg
module cc2v_line_buf (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [cc2v_pkg::SLOT_W-1:0]           wr_slot,
    input  logic [cc2v_pkg::ADDR_W-1:0]           addr,
    input  logic signed [cc2v_pkg::PIXEL_BITS-1:0] wr_data,
    output logic signed [cc2v_pkg::PIXEL_BITS-1:0] rd_data [cc2v_pkg::MAX_KERNEL]
);

    for (genvar k = 0; k < cc2v_pkg::MAX_KERNEL; k++)
    begin : g_bank
        logic signed [cc2v_pkg::PIXEL_BITS-1:0] mem [cc2v_pkg::MAX_WIDTH];

        always_ff @(posedge clk)
        begin
            if (wr_en && wr_slot == cc2v_pkg::SLOT_W'(k))
            begin
                mem[addr] <= wr_data;
            end
            if (wr_en)
            begin
                rd_data[k] <= mem[addr];
            end
        end
    end

endmodule

FILE: rtl/cc2v_cell.sv
// cc2v_cell: one window position holding a pixel and its coefficient
// passes the pixel to its neighbour and registers pixel times coefficient
// depends on cc2v_pkg
module cc2v_cell (
    input  logic                                   clk,
    input  cc2v_pkg::cell_ctrl_t                   ctrl,
    input  logic signed [cc2v_pkg::PIXEL_BITS-1:0] pix_in,
    input  logic signed [cc2v_pkg::PIXEL_BITS-1:0] coef_in,
    output logic signed [cc2v_pkg::PIXEL_BITS-1:0] pix,
    output logic signed [cc2v_pkg::PROD_W-1:0]     prod
);

    logic signed [cc2v_pkg::PIXEL_BITS-1:0] pix_reg;
    logic signed [cc2v_pkg::PIXEL_BITS-1:0] coef_reg;
    logic signed [cc2v_pkg::PROD_W-1:0]     prod_reg;
    logic signed [cc2v_pkg::PROD_W-1:0]     mult;

    assign mult = pix_reg * coef_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            pix_reg <= pix_in;
        end
        if (ctrl.capture)
        begin
            coef_reg <= coef_in;
            // positions outside the kernel give zero whatever pixel they hold
            prod_reg <= (coef_reg == '0) ? '0 : mult;
        end
    end

    assign pix  = pix_reg;
    assign prod = prod_reg;

endmodule

FILE: rtl/cross_correlation_2d_valid_unit.sv
// cross_correlation_2d_valid_unit: streaming valid-mode 2d cross-correlation
// a window-completing pixel beat passes s1, s2, s3, s4 and the output register
// throughput: one beat per cycle unless stalled, set by single-port banks and cell row
// reset: registers return to 256, 256, 3, 3; coefficients zero; counters zero
// depends on cc2v_pkg, cc2v_line_buf, cc2v_cell
module cross_correlation_2d_valid_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   pix_valid,
    output logic                                   pix_stall,
    input  cc2v_pkg::in_t                          pix_data,
    output logic                                   res_valid,
    input  logic                                   res_stall,
    output cc2v_pkg::out_t                         res_data,
    input  logic                                   cfg_we,
    input  logic [cc2v_pkg::CFGIDX_W-1:0]          cfg_index,
    input  logic [cc2v_pkg::CFG_W-1:0]             cfg_data
);

    localparam int K  = cc2v_pkg::MAX_KERNEL;
    localparam int PB = cc2v_pkg::PIXEL_BITS;

    logic [cc2v_pkg::WIDTH_W-1:0]  width_reg;
    logic [cc2v_pkg::HEIGHT_W-1:0] height_reg;
    logic [cc2v_pkg::KDIM_W-1:0]   krows_reg;
    logic [cc2v_pkg::KDIM_W-1:0]   kcols_reg;
    logic [cc2v_pkg::WIDTH_W-1:0]  w_eff;
    logic [cc2v_pkg::HEIGHT_W-1:0] h_eff;
    logic [cc2v_pkg::KDIM_W-1:0]   kr_eff;
    logic [cc2v_pkg::KDIM_W-1:0]   kc_eff;

    logic [cc2v_pkg::ADDR_W-1:0]   col_reg;
    logic [cc2v_pkg::ADDR_W-1:0]   col_next;
    logic [cc2v_pkg::ROWCNT_W-1:0] row_reg;
    logic [cc2v_pkg::ROWCNT_W-1:0] row_next;
    logic [cc2v_pkg::SLOT_W-1:0]   slot_reg;
    logic [cc2v_pkg::SLOT_W-1:0]   slot_next;

    logic signed [PB-1:0] coef_reg [cc2v_pkg::KSLOTS];

    logic en;
    logic pix_acc;
    logic coef_acc;
    logic emit;
    logic at_last;
    logic row_end;

    logic                          s1_valid_reg;
    logic                          s1_emit_reg;
    logic                          s1_last_reg;
    logic signed [PB-1:0]          s1_pix_reg;
    logic [cc2v_pkg::SLOT_W-1:0]   s1_slot_reg;
    logic                          s2_valid_reg;
    logic                          s2_last_reg;
    logic                          s3_valid_reg;
    logic                          s3_last_reg;
    logic                          s4_valid_reg;
    logic                          s4_last_reg;
    logic                          out_valid_reg;
    logic                          out_last_reg;
    logic signed [cc2v_pkg::SUM_W-1:0] out_sum_reg;

    logic signed [PB-1:0] rd_data [K];
    logic signed [PB-1:0] column [K];
    logic signed [PB-1:0] win [K][K];
    logic signed [PB-1:0] cell_coef [K][K];
    logic signed [cc2v_pkg::PROD_W-1:0] prod [K][K];
    logic signed [cc2v_pkg::ROW_W-1:0]  rowsum_reg [K];
    logic signed [cc2v_pkg::ROW_W-1:0]  rowsum_next [K];
    logic signed [cc2v_pkg::SUM_W-1:0]  total;
    cc2v_pkg::cell_ctrl_t cell_ctrl;

    // effective register values
    always_comb
    begin
        if (width_reg == '0)
            w_eff = cc2v_pkg::WIDTH_W'(1);
        else if (width_reg > cc2v_pkg::WIDTH_MAX)
            w_eff = cc2v_pkg::WIDTH_MAX;
        else
            w_eff = width_reg;
        if (height_reg == '0)
            h_eff = cc2v_pkg::HEIGHT_W'(1);
        else if (height_reg > cc2v_pkg::HEIGHT_MAX)
            h_eff = cc2v_pkg::HEIGHT_MAX;
        else
            h_eff = height_reg;
        if (krows_reg == '0)
            kr_eff = cc2v_pkg::KDIM_W'(1);
        else if (krows_reg > cc2v_pkg::KDIM_MAX)
            kr_eff = cc2v_pkg::KDIM_MAX;
        else
            kr_eff = krows_reg;
        if (kcols_reg == '0)
            kc_eff = cc2v_pkg::KDIM_W'(1);
        else if (kcols_reg > cc2v_pkg::KDIM_MAX)
            kc_eff = cc2v_pkg::KDIM_MAX;
        else
            kc_eff = kcols_reg;
    end

    assign en        = !(out_valid_reg && res_stall);
    assign pix_stall = !en;
    assign pix_acc   = pix_valid && en && pix_data.op == cc2v_pkg::OP_PIXEL;
    assign coef_acc  = pix_valid && en && pix_data.op == cc2v_pkg::OP_COEF;

    assign emit = (row_reg >= cc2v_pkg::ROWCNT_W'(kr_eff - 3'd1))
                  && ({1'b0, col_reg} >= cc2v_pkg::WIDTH_W'(kc_eff - 3'd1));
    assign row_end = ({1'b0, col_reg} == w_eff - cc2v_pkg::WIDTH_W'(1));
    assign at_last = row_end && ({1'b0, row_reg} == h_eff - cc2v_pkg::HEIGHT_W'(1));

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        slot_next = slot_reg;
        if (pix_acc)
        begin
            if (row_end)
            begin
                col_next = '0;
                if ({1'b0, row_reg} == h_eff - cc2v_pkg::HEIGHT_W'(1))
                begin
                    row_next  = '0;
                    slot_next = '0;
                end
                else
                begin
                    row_next  = row_reg + cc2v_pkg::ROWCNT_W'(1);
                    slot_next = (slot_reg == cc2v_pkg::SLOT_W'(K - 1)) ? '0
                                : slot_reg + cc2v_pkg::SLOT_W'(1);
                end
            end
            else
            begin
                col_next = col_reg + cc2v_pkg::ADDR_W'(1);
            end
        end
    end

    // configuration and position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= cc2v_pkg::WIDTH_W'(256);
            height_reg <= cc2v_pkg::HEIGHT_W'(256);
            krows_reg  <= cc2v_pkg::KDIM_W'(3);
            kcols_reg  <= cc2v_pkg::KDIM_W'(3);
            col_reg    <= '0;
            row_reg    <= '0;
            slot_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cc2v_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data[cc2v_pkg::WIDTH_W-1:0];
                cc2v_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                cc2v_pkg::REG_KERNEL_ROWS:  krows_reg  <= cfg_data[cc2v_pkg::KDIM_W-1:0];
                cc2v_pkg::REG_KERNEL_COLS:  kcols_reg  <= cfg_data[cc2v_pkg::KDIM_W-1:0];
                default:                    width_reg  <= width_reg;
            endcase
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            slot_reg <= slot_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < cc2v_pkg::KSLOTS; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (coef_acc && pix_data.kernel_index < cc2v_pkg::KIDX_W'(cc2v_pkg::KSLOTS))
        begin
            coef_reg[pix_data.kernel_index] <= pix_data.value;
        end
    end

    cc2v_line_buf u_line_buf (
        .clk     (clk),
        .wr_en   (pix_acc),
        .wr_slot (slot_reg),
        .addr    (col_reg),
        .wr_data (pix_data.value),
        .rd_data (rd_data)
    );

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= pix_acc;
            s2_valid_reg  <= s1_valid_reg && s1_emit_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            out_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (pix_acc)
            begin
                s1_emit_reg <= emit;
                s1_last_reg <= at_last;
                s1_pix_reg  <= pix_data.value;
                s1_slot_reg <= slot_reg;
            end
            s2_last_reg  <= s1_last_reg;
            s3_last_reg  <= s2_last_reg;
            s4_last_reg  <= s3_last_reg;
            out_last_reg <= s4_last_reg;
            out_sum_reg  <= total;
            for (int a = 0; a < K; a++)
            begin
                rowsum_reg[a] <= rowsum_next[a];
            end
        end
    end

    // column of the newest pixel and the rows above it
    always_comb
    begin
        logic [cc2v_pkg::SLOT_W:0] t;
        for (int a = 0; a < K; a++)
        begin
            t = {1'b0, s1_slot_reg} + (cc2v_pkg::SLOT_W + 1)'(K - a);
            if (t >= (cc2v_pkg::SLOT_W + 1)'(K))
                t = t - (cc2v_pkg::SLOT_W + 1)'(K);
            if (a == 0)
                column[a] = s1_pix_reg;
            else
                column[a] = rd_data[t[cc2v_pkg::SLOT_W-1:0]];
        end
    end

    assign cell_ctrl.shift   = en && s1_valid_reg;
    assign cell_ctrl.capture = en;

    // coefficient for window row a (0 newest) and column b (0 newest)
    always_comb
    begin
        logic [cc2v_pkg::KDIM_W-1:0] ci;
        logic [cc2v_pkg::KDIM_W-1:0] cj;
        logic [cc2v_pkg::KIDX_W-1:0] idx;
        for (int a = 0; a < K; a++)
        begin
            for (int b = 0; b < K; b++)
            begin
                ci  = kr_eff - cc2v_pkg::KDIM_W'(a + 1);
                cj  = kc_eff - cc2v_pkg::KDIM_W'(b + 1);
                idx = cc2v_pkg::KIDX_W'(ci) * cc2v_pkg::KIDX_W'(kc_eff)
                      + cc2v_pkg::KIDX_W'(cj);
                if (cc2v_pkg::KDIM_W'(a) < kr_eff && cc2v_pkg::KDIM_W'(b) < kc_eff)
                    cell_coef[a][b] = coef_reg[idx];
                else
                    cell_coef[a][b] = '0;
            end
        end
    end

    for (genvar a = 0; a < K; a++)
    begin : g_row
        for (genvar b = 0; b < K; b++)
        begin : g_col
            cc2v_cell u_cell (
                .clk     (clk),
                .ctrl    (cell_ctrl),
                .pix_in  ((b == 0) ? column[a] : win[a][(b == 0) ? 0 : b - 1]),
                .coef_in (cell_coef[a][b]),
                .pix     (win[a][b]),
                .prod    (prod[a][b])
            );
        end
    end

    always_comb
    begin
        for (int a = 0; a < K; a++)
        begin
            rowsum_next[a] = '0;
            for (int b = 0; b < K; b++)
            begin
                rowsum_next[a] = rowsum_next[a] + cc2v_pkg::ROW_W'(prod[a][b]);
            end
        end
        total = '0;
        for (int a = 0; a < K; a++)
        begin
            total = total + cc2v_pkg::SUM_W'(rowsum_reg[a]);
        end
    end

    assign res_valid     = out_valid_reg;
    assign res_data.sum  = out_sum_reg;
    assign res_data.last = out_last_reg;

endmodule

FILE: rtl/cc2v_checker.sv
// cc2v_assertions: port-level checks for the cross-correlation unit
// bound to cross_correlation_2d_valid_unit; depends on cc2v_pkg
module cc2v_assertions (
    input logic           clk,
    input logic           rst_n,
    input logic           pix_stall,
    input logic           res_valid,
    input logic           res_stall,
    input cc2v_pkg::out_t res_data
);

    // a held result beat keeps its payload
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("result beat changed while stalled");

    // input only backs up behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pix_stall |-> res_valid && res_stall)
        else $error("input stalled without a waiting result");

    // free output side never holds the input
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !res_stall |-> !pix_stall)
        else $error("input stalled with output free");

    // a result beat only leaves once taken
    a_res_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(res_valid) |-> $past(!res_stall))
        else $error("result beat dropped");

endmodule

bind cross_correlation_2d_valid_unit cc2v_assertions u_cc2v_assertions (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_stall (pix_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
);

FILE: tb/cc2v_checker.sv
// cc2v_checker: watches the pixel, result and register channels of the 2d cross-correlation unit
// keeps its own window-sum predictor, compares every result beat and counts failures
// depends on cc2v_pkg
module cc2v_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pix_valid,
    input  logic                          pix_stall,
    input  cc2v_pkg::in_t                 pix_data,
    input  logic                          res_valid,
    input  logic                          res_stall,
    input  cc2v_pkg::out_t                res_data,
    input  logic                          cfg_we,
    input  logic [cc2v_pkg::CFGIDX_W-1:0] cfg_index,
    input  logic [cc2v_pkg::CFG_W-1:0]    cfg_data,
    output int                            fails,
    output int                            pending,
    output int                            results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [cc2v_pkg::WIDTH_W-1:0]           width_reg;
    logic [cc2v_pkg::HEIGHT_W-1:0]          height_reg;
    logic [cc2v_pkg::KDIM_W-1:0]            krows_reg;
    logic [cc2v_pkg::KDIM_W-1:0]            kcols_reg;
    logic signed [cc2v_pkg::PIXEL_BITS-1:0] coefs [cc2v_pkg::KSLOTS];
    logic signed [cc2v_pkg::PIXEL_BITS-1:0] rows_held [cc2v_pkg::MAX_KERNEL][cc2v_pkg::MAX_WIDTH];
    int                                     col_pos;
    int                                     row_pos;
    cc2v_pkg::out_t                         window_sums [$];

    function automatic int limit_dim(int v, int hi);
        if (v == 0)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    task automatic take_pixel(logic signed [cc2v_pkg::PIXEL_BITS-1:0] px);
        int    w;
        int    h;
        int    kr;
        int    kc;
        int    r;
        int    c;
        longint acc;
        cc2v_pkg::out_t res;
        w  = limit_dim(width_reg, cc2v_pkg::MAX_WIDTH);
        h  = limit_dim(height_reg, 4096);
        kr = limit_dim(krows_reg, cc2v_pkg::MAX_KERNEL);
        kc = limit_dim(kcols_reg, cc2v_pkg::MAX_KERNEL);
        r  = (row_pos >= h) ? h - 1 : row_pos;
        c  = (col_pos >= w) ? w - 1 : col_pos;
        rows_held[r % cc2v_pkg::MAX_KERNEL][c] = px;
        if (r + 1 >= kr && c + 1 >= kc)
        begin
            acc = 0;
            for (int i = 0; i < kr; i++)
                for (int j = 0; j < kc; j++)
                    acc += longint'(coefs[i * kc + j])
                         * longint'(rows_held[(r + 1 - kr + i) % cc2v_pkg::MAX_KERNEL]
                                             [c + 1 - kc + j]);
            res.sum  = acc[cc2v_pkg::SUM_W-1:0];
            res.last = (r == h - 1 && c == w - 1);
            window_sums.push_back(res);
        end
        if (c + 1 >= w)
        begin
            c = 0;
            r = (r + 1 >= h) ? 0 : r + 1;
        end
        else
            c++;
        col_pos = c;
        row_pos = r;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  = cc2v_pkg::WIDTH_W'(256);
            height_reg = cc2v_pkg::HEIGHT_W'(256);
            krows_reg  = cc2v_pkg::KDIM_W'(3);
            kcols_reg  = cc2v_pkg::KDIM_W'(3);
            foreach (coefs[k])
                coefs[k] = '0;
            col_pos = 0;
            row_pos = 0;
            window_sums.delete();
            fails = 0;
            pending = 0;
            results_seen = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    cc2v_pkg::REG_IMAGE_WIDTH:  width_reg  = cfg_data[cc2v_pkg::WIDTH_W-1:0];
                    cc2v_pkg::REG_IMAGE_HEIGHT: height_reg = cfg_data[cc2v_pkg::HEIGHT_W-1:0];
                    cc2v_pkg::REG_KERNEL_ROWS:  krows_reg  = cfg_data[cc2v_pkg::KDIM_W-1:0];
                    cc2v_pkg::REG_KERNEL_COLS:  kcols_reg  = cfg_data[cc2v_pkg::KDIM_W-1:0];
                    default: ;
                endcase
                col_pos = 0;
                row_pos = 0;
            end
            if (pix_valid && !pix_stall)
            begin
                if (pix_data.op == cc2v_pkg::OP_COEF)
                begin
                    if (pix_data.kernel_index < cc2v_pkg::KSLOTS)
                        coefs[pix_data.kernel_index] = pix_data.value;
                end
                else
                    take_pixel(pix_data.value);
            end
            if (res_valid && !res_stall)
            begin
                results_seen++;
                if (window_sums.size() == 0)
                begin
                    fails++;
                    $display("%0t: unexpected result beat: expected none, actual sum %0d last %0b",
                             $time, res_data.sum, res_data.last);
                end
                else
                begin
                    if (res_data.sum !== window_sums[0].sum)
                    begin
                        fails++;
                        $display("%0t: sum mismatch: expected %0d, actual %0d",
                                 $time, window_sums[0].sum, res_data.sum);
                    end
                    if (res_data.last !== window_sums[0].last)
                    begin
                        fails++;
                        $display("%0t: last mismatch: expected %0b, actual %0b",
                                 $time, window_sums[0].last, res_data.last);
                    end
                    void'(window_sums.pop_front());
                end
            end
            pending = window_sums.size();
        end
    end

endmodule

FILE: tb/cross_correlation_2d_valid_unit_tb.sv
// cross_correlation_2d_valid_unit_tb: stimulus and verdict for the 2d cross-correlation unit
// directed register extremes and coefficient/pixel extremes, then random images and kernels
// depends on cc2v_pkg, cross_correlation_2d_valid_unit, cc2v_checker
module cross_correlation_2d_valid_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic                          clk;
    logic                          rst_n;
    logic                          pix_valid;
    logic                          pix_stall;
    cc2v_pkg::in_t                 pix_data;
    logic                          res_valid;
    logic                          res_stall;
    cc2v_pkg::out_t                res_data;
    logic                          cfg_we;
    logic [cc2v_pkg::CFGIDX_W-1:0] cfg_index;
    logic [cc2v_pkg::CFG_W-1:0]    cfg_data;
    int                            fails;
    int                            pending;
    int                            results_seen;
    int                            pixels_sent;
    int                            coefs_sent;
    int                            phases;
    bit                            calm;

    cross_correlation_2d_valid_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_data  (pix_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cc2v_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .pix_valid    (pix_valid),
        .pix_stall    (pix_stall),
        .pix_data     (pix_data),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .res_data     (res_data),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fails        (fails),
        .pending      (pending),
        .results_seen (results_seen)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #5ms;
        $display("FAIL");
        $finish;
    end

    function automatic int pick_gap();
        if (calm)
            return 0;
        return $urandom_range(0, 6);
    endfunction

    function automatic logic signed [cc2v_pkg::PIXEL_BITS-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'shffff;
            default: return cc2v_pkg::PIXEL_BITS'($urandom);
        endcase
    endfunction

    task automatic send_beat(logic op, logic [cc2v_pkg::KIDX_W-1:0] kidx,
                             logic signed [cc2v_pkg::PIXEL_BITS-1:0] v);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_data  <= '{op: op, kernel_index: kidx, value: v};
        @(negedge clk);
        while (pix_stall)
            @(negedge clk);
        @(posedge clk);
        if (op == cc2v_pkg::OP_PIXEL)
            pixels_sent++;
        else
            coefs_sent++;
    endtask

    task automatic drain();
        pix_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
    endtask

    task automatic set_image(int w, int h, int kr, int kc);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= cc2v_pkg::REG_IMAGE_WIDTH;
        cfg_data <= cc2v_pkg::CFG_W'(w);
        @(posedge clk);
        cfg_index <= cc2v_pkg::REG_IMAGE_HEIGHT;
        cfg_data <= cc2v_pkg::CFG_W'(h);
        @(posedge clk);
        cfg_index <= cc2v_pkg::REG_KERNEL_ROWS;
        cfg_data <= cc2v_pkg::CFG_W'(kr);
        @(posedge clk);
        cfg_index <= cc2v_pkg::REG_KERNEL_COLS;
        cfg_data <= cc2v_pkg::CFG_W'(kc);
        @(posedge clk);
        cfg_we <= 1'b0;
        phases++;
    endtask

    initial
    begin
        int n;
        forever
        begin
            n = pick_gap();
            repeat (n)
            begin
                res_stall <= 1'b1;
                @(posedge clk);
            end
            res_stall <= 1'b0;
            @(negedge clk);
            while (!res_valid)
                @(negedge clk);
            @(posedge clk);
        end
    end

    initial
    begin
        int w;
        int h;
        int kr;
        int kc;
        int npix;
        rst_n = 1'b0;
        pix_valid = 1'b0;
        pix_data = '0;
        res_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pixels_sent = 0;
        coefs_sent = 0;
        phases = 0;
        calm = 1'b0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset sizes, partial image only
        send_beat(cc2v_pkg::OP_COEF, 5'd0, 16'sh7fff);
        send_beat(cc2v_pkg::OP_PIXEL, 5'd0, 16'sh8000);
        send_beat(cc2v_pkg::OP_PIXEL, 5'd0, 16'sh7fff);

        // 3x3 image with 3x3 kernel: one result, marked last
        set_image(3, 3, 3, 3);
        for (int k = 0; k < 9; k++)
            send_beat(cc2v_pkg::OP_COEF, cc2v_pkg::KIDX_W'(k),
                      (k % 2) ? 16'sh8000 : 16'sh7fff);
        for (int k = 0; k < 9; k++)
            send_beat(cc2v_pkg::OP_PIXEL, 5'd0, (k % 3) ? 16'sh8000 : 16'sh7fff);

        // zero registers act as one, out-of-range coefficient index ignored
        set_image(0, 0, 0, 0);
        send_beat(cc2v_pkg::OP_COEF, 5'd31, 16'sh1234);
        send_beat(cc2v_pkg::OP_COEF, 5'd25, 16'sh4321);
        for (int k = 0; k < 3; k++)
            send_beat(cc2v_pkg::OP_PIXEL, 5'd0, pick_value());

        // kernel larger than the image gives nothing
        set_image(2, 2, 7, 7);
        for (int k = 0; k < 4; k++)
            send_beat(cc2v_pkg::OP_PIXEL, 5'd0, pick_value());

        // register values above their bounds saturate
        set_image(511, 8191, 5, 5);
        for (int k = 0; k < 6; k++)
            send_beat(cc2v_pkg::OP_PIXEL, 5'd0, pick_value());
        set_image(256, 4096, 1, 1);
        for (int k = 0; k < 4; k++)
            send_beat(cc2v_pkg::OP_PIXEL, 5'd0, pick_value());

        while (pixels_sent + coefs_sent < 440)
        begin
            calm = ($urandom_range(0, 4) == 0);
            w  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 8);
            h  = $urandom_range(0, 6);
            kr = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
            kc = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
            set_image(w, h, kr, kc);
            n_coefs_loop: for (int k = $urandom_range(2, 10); k > 0; k--)
                send_beat(cc2v_pkg::OP_COEF, cc2v_pkg::KIDX_W'($urandom_range(0, 31)),
                          pick_value());
            npix = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h) * $urandom_range(1, 2);
            npix = npix + $urandom_range(0, 3);
            if (npix > 120)
                npix = 120;
            for (int k = 0; k < npix; k++)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_beat(cc2v_pkg::OP_COEF, cc2v_pkg::KIDX_W'($urandom_range(0, 31)),
                              pick_value());
                if (phases == 10 && k == npix / 2)
                    drain();
                send_beat(cc2v_pkg::OP_PIXEL, cc2v_pkg::KIDX_W'($urandom), pick_value());
            end
        end

        drain();
        repeat (20)
            @(posedge clk);
        $display("covered %0d pixel beats and %0d coefficient beats over %0d image setups",
                 pixels_sent, coefs_sent, phases);
        $display("%0d result beats checked, %0d failures", results_seen, fails);
        if (fails == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
